### hdl/url_scheme_blacklist_matcher_unit_assert.svh
// Assertion macros for the URL scheme matcher, clocked on clk_i, disabled in reset.
`ifndef URL_SCHEME_BLACKLIST_MATCHER_UNIT_ASSERT_SVH
`define URL_SCHEME_BLACKLIST_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define USBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("usbm assertion failed");

// Next-cycle implication.
`define USBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("usbm assertion failed");

`endif

### hdl/usbm_pkg.sv
// Types, keyword tables and matching functions of the URL scheme matcher.
package usbm_pkg;

  localparam int KW_N = 4;
  localparam int ACC_W = 21;
  localparam int WIDE_W = 25;
  localparam logic [WIDE_W-1:0] ENTITY_LIMIT = 25'h10_00FF;

  // Keyword order: DATA, VIEW-SOURCE, JAVA, VBSCRIPT
  localparam logic [KW_N-1:0][3:0] KW_LEN  = {4'd8, 4'd4, 4'd11, 4'd4};
  localparam logic [KW_N-1:0][2:0] KW_CODE = {3'd4, 3'd3, 3'd2, 3'd1};
  localparam logic [2:0] CODE_NONE = 3'd0;

  localparam logic [7:0] CH_AMP  = "&";
  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_X_LO = "x";
  localparam logic [7:0] CH_X_UP = "X";
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_AMP   = 3'd1,
    PH_HASH  = 3'd2,
    PH_HASHX = 3'd3,
    PH_DEC   = 3'd4,
    PH_HEX   = 3'd5
  } phase_e;

  typedef struct packed {
    logic                  leading;
    logic [KW_N-1:0]       alive;
    logic [KW_N-1:0][3:0]  pos;
    logic [2:0]            found;
  } match_t;

  typedef struct packed {
    phase_e                phase;
    logic [ACC_W-1:0]      acc;
    match_t                m;
  } dec_t;

  typedef struct packed {
    dec_t st;
    logic redo;
  } dec_res_t;

  function automatic dec_t dec_reset();
    dec_t s;
    s.phase     = PH_IDLE;
    s.acc       = '0;
    s.m.leading = 1'b1;
    s.m.alive   = '1;
    s.m.pos     = '0;
    s.m.found   = CODE_NONE;
    return s;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] k, logic [3:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        case (p)
          4'd0: c = "D";
          4'd1: c = "A";
          4'd2: c = "T";
          4'd3: c = "A";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (p)
          4'd0:  c = "V";
          4'd1:  c = "I";
          4'd2:  c = "E";
          4'd3:  c = "W";
          4'd4:  c = "-";
          4'd5:  c = "S";
          4'd6:  c = "O";
          4'd7:  c = "U";
          4'd8:  c = "R";
          4'd9:  c = "C";
          4'd10: c = "E";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (p)
          4'd0: c = "J";
          4'd1: c = "A";
          4'd2: c = "V";
          4'd3: c = "A";
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (p)
          4'd0: c = "V";
          4'd1: c = "B";
          4'd2: c = "S";
          4'd3: c = "C";
          4'd4: c = "R";
          4'd5: c = "I";
          4'd6: c = "P";
          4'd7: c = "T";
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  // Feed one decoded character to all keyword matchers.
  function automatic match_t deliver(match_t m, logic [ACC_W-1:0] c);
    match_t r;
    logic [ACC_W-1:0] cu;
    logic [7:0] low;
    r = m;
    if (!(m.leading && c <= ACC_W'(32))) begin
      r.leading = 1'b0;
      if (c != '0 && c != ACC_W'(10)) begin
        cu = (c >= ACC_W'(97) && c <= ACC_W'(122)) ? c - ACC_W'(32) : c;
        low = cu[7:0];
        for (int k = 0; k < KW_N; k++) begin
          if (r.alive[k] && r.pos[k] < KW_LEN[k]) begin
            if (kw_char(2'(k), r.pos[k]) == low) begin
              r.pos[k] = r.pos[k] + 4'd1;
              if (r.pos[k] == KW_LEN[k] && r.found == CODE_NONE) begin
                r.found = KW_CODE[k];
              end
            end else begin
              r.alive[k] = 1'b0;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Kill every keyword not yet complete and end the leading phase.
  function automatic match_t kill_all(match_t m);
    match_t r;
    r = m;
    r.leading = 1'b0;
    for (int k = 0; k < KW_N; k++) begin
      if (r.pos[k] < KW_LEN[k]) r.alive[k] = 1'b0;
    end
    return r;
  endfunction

endpackage

### hdl/usbm_if.sv
// Stream interfaces for the byte input and the scheme result of the matcher.
interface usbm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface usbm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] scheme_code;

  modport source (output valid, output scheme_code, input ready);
  modport sink   (input valid, input scheme_code, output ready);
endinterface

### hdl/usbm_step.sv
// Next-state logic for one byte: raw skip, entity decode, keyword match, end of token.
module usbm_step import usbm_pkg::*; (
  input  logic       raw_skip_i,
  input  dec_t       st_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       raw_skip_o,
  output dec_t       st_o,
  output logic [2:0] code_o
);

  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = 5'b0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - "0")};
    else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - "a" + 8'd10)};
    else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - "A" + 8'd10)};
    return r;
  endfunction

  function automatic dec_res_t decode(dec_t s, logic [7:0] b);
    dec_res_t r;
    logic bad;
    logic [4:0] d;
    logic [WIDE_W-1:0] wide;
    r.st = s;
    r.redo = 1'b0;
    bad = 1'b0;
    d = 5'b0;
    wide = '0;
    case (s.phase)
      PH_IDLE: begin
        if (b == CH_AMP) r.st.phase = PH_AMP;
        else r.st.m = deliver(s.m, ACC_W'(b));
      end
      PH_AMP: begin
        if (b == CH_HASH) r.st.phase = PH_HASH;
        else bad = 1'b1;
      end
      PH_HASH: begin
        if (b == CH_X_LO || b == CH_X_UP) begin
          r.st.phase = PH_HASHX;
        end else if (b >= "0" && b <= "9") begin
          r.st.acc = ACC_W'(b - "0");
          r.st.phase = PH_DEC;
        end else begin
          bad = 1'b1;
        end
      end
      PH_HASHX: begin
        d = hex_digit(b);
        if (d[4]) begin
          r.st.acc = ACC_W'(d[3:0]);
          r.st.phase = PH_HEX;
        end else begin
          bad = 1'b1;
        end
      end
      PH_DEC, PH_HEX: begin
        if (b == CH_SEMI) begin
          r.st.m = deliver(s.m, s.acc);
          r.st.phase = PH_IDLE;
        end else begin
          if (s.phase == PH_DEC) d = (b >= "0" && b <= "9") ? {1'b1, 4'(b - "0")} : 5'b0;
          else d = hex_digit(b);
          if (!d[4]) begin
            // entity ends on a non-digit: deliver, then decode this byte again
            r.st.m = deliver(s.m, s.acc);
            r.st.phase = PH_IDLE;
            r.redo = 1'b1;
          end else begin
            if (s.phase == PH_DEC) wide = WIDE_W'(s.acc) * WIDE_W'(10) + WIDE_W'(d[3:0]);
            else wide = {s.acc, d[3:0]};
            if (wide > ENTITY_LIMIT) begin
              r.st.m = kill_all(s.m);
              r.st.phase = PH_IDLE;
              r.st.acc = '0;
            end else begin
              r.st.acc = wide[ACC_W-1:0];
            end
          end
        end
      end
      default: begin
        r.st.phase = PH_IDLE;
        r.redo = 1'b1;
      end
    endcase
    if (bad) begin
      // malformed entity decodes as '&'
      r.st.m = kill_all(s.m);
      r.st.phase = PH_IDLE;
      r.redo = 1'b1;
    end
    return r;
  endfunction

  dec_res_t r1;
  dec_res_t r2;
  dec_t     st_b;
  dec_t     st_e;
  logic     drop_raw;

  always_comb begin
    drop_raw = raw_skip_i && (byte_i <= CH_SPACE || byte_i >= CH_DEL);
    r1 = decode(st_i, byte_i);
    r2 = decode(r1.st, byte_i);
    if (drop_raw) st_b = st_i;
    else if (r1.redo) st_b = r2.st;
    else st_b = r1.st;

    // close any open entity at the end of the token
    st_e = st_b;
    if (st_b.phase == PH_DEC || st_b.phase == PH_HEX) st_e.m = deliver(st_b.m, st_b.acc);
    else if (st_b.phase != PH_IDLE) st_e.m = kill_all(st_b.m);
    code_o = st_e.m.found;

    if (last_i) begin
      raw_skip_o = 1'b1;
      st_o = dec_reset();
    end else begin
      raw_skip_o = raw_skip_i && drop_raw;
      st_o = st_b;
    end
  end

endmodule

### hdl/url_scheme_blacklist_matcher_unit.sv
// Path: a byte taken at the input is held in the input register; on its last byte the
// scheme code is written into the result register once that register is free.
// Throughput: one byte per cycle; the input register and the result register decouple
// the two sides, so a waiting result stalls input only when another last byte is due.
// Reset: rst_ni clears both registers' valid flags and returns the matcher to its
// token-start state.
`include "url_scheme_blacklist_matcher_unit_assert.svh"

module url_scheme_blacklist_matcher_unit import usbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  usbm_in_if.sink     in_i,
  usbm_out_if.source  out_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       raw_skip_q, raw_skip_d;
  dec_t       st_q, st_d;
  logic       out_valid_q;
  logic [2:0] code_q, code_d;
  logic       out_free;
  logic       adv;

  assign out_free   = !out_valid_q || out_o.ready;
  assign adv        = in_valid_q && (!in_last_q || out_free);
  assign in_i.ready = !in_valid_q || adv;

  assign out_o.valid       = out_valid_q;
  assign out_o.scheme_code = code_q;

  usbm_step u_step (
    .raw_skip_i (raw_skip_q),
    .st_i       (st_q),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .raw_skip_o (raw_skip_d),
    .st_o       (st_d),
    .code_o     (code_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      raw_skip_q  <= 1'b1;
      st_q        <= dec_reset();
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (adv) begin
        raw_skip_q <= raw_skip_d;
        st_q       <= st_d;
      end
      if (adv && in_last_q) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.byte_value;
      in_last_q <= in_i.last_byte;
    end
    if (adv && in_last_q) code_q <= code_d;
  end

  `USBM_ASSERT_NOW(a_code_range, out_valid_q, code_q <= 3'd4)
  `USBM_ASSERT_NEXT(a_token_restart, adv && in_last_q, raw_skip_q && st_q.phase == PH_IDLE)
  `USBM_ASSERT_NEXT(a_no_result_mid_token, adv && !in_last_q && !out_valid_q, !out_valid_q)
  `USBM_ASSERT_NOW(a_found_is_complete, st_q.m.found != CODE_NONE,
                   st_q.m.pos[0] == KW_LEN[0] || st_q.m.pos[1] == KW_LEN[1] ||
                   st_q.m.pos[2] == KW_LEN[2] || st_q.m.pos[3] == KW_LEN[3])

endmodule
